@@ hw/rtl/apr_pkg.sv @@
// ----------------------------------------------------------------------------
// Aging page replacement package
// Shared constants, register codes and sequencer states for the aging
// page replacement block.
// ----------------------------------------------------------------------------
package apr_pkg;

  // Default table geometry.
  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 20;

  // Age counter.
  localparam int            AGE_W   = 8;
  localparam logic [AGE_W-1:0] AGE_TOP = 8'h80;

  // Result frame index field.
  localparam int IDX_OUT_W = 4;

  // Configuration register.
  localparam int             CFG_W     = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // APB port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_AGE,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/apr_in_if.sv @@
// ----------------------------------------------------------------------------
// Page reference channel
// Valid/ready channel that carries one referenced page number per beat.
// ----------------------------------------------------------------------------
interface apr_in_if #(
  parameter int PAGE_BITS = apr_pkg::PAGE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

@@ hw/rtl/apr_out_if.sv @@
// ----------------------------------------------------------------------------
// Replacement result channel
// Valid/ready channel that carries one lookup/replacement result per beat.
// ----------------------------------------------------------------------------
interface apr_out_if #(
  parameter int PAGE_BITS = apr_pkg::PAGE_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [apr_pkg::IDX_OUT_W-1:0]  frame_index;
  logic                           evicted_valid;
  logic [PAGE_BITS-1:0]           evicted_page;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, output ready);
endinterface

@@ hw/rtl/aging_page_replacement.sv @@
// ----------------------------------------------------------------------------
// Aging page replacement
// Frame table with lookup, fill, smallest-age eviction and 8-bit aging.
// ----------------------------------------------------------------------------
// One page reference is handled at a time: after acceptance the block runs a scan
// pass over the n active frames, a fill step, an aging pass over the same frames
// and its done step before it returns to idle for the next acceptance; each pass
// also waits out the registered read of the last frame.
// If the previous result still waits unaccepted in the output register, the
// block holds in its done step until that beat leaves. Page numbers and ages
// sit in two single-port-read RAMs, so the block walks the active frames twice,
// one frame per cycle: a first pass compares each frame's page and age to find
// a hit, the lowest free frame and the oldest frame, and a second pass
// rewrites every valid age through the shifter. A finished result waits in
// the output register while the next reference is already accepted.
module aging_page_replacement #(
  parameter int FRAMES    = apr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = apr_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  apr_in_if.sink                            in_ch,
  apr_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [apr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [apr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [apr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int IDX_W = $clog2(FRAMES);
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int LIM_W = (CNT_W > apr_pkg::CFG_W) ? CNT_W : apr_pkg::CFG_W;
  localparam int AGE_W = apr_pkg::AGE_W;

  // Configuration.
  logic [apr_pkg::CFG_W-1:0]     frames_in_use_r;
  logic [apr_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;
  logic [LIM_W-1:0]              lim_ext;
  logic [CNT_W-1:0]              n_act;

  // Sequencer.
  apr_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 chk_v_r;
  logic [IDX_W-1:0]     chk_idx_r;
  logic [FRAMES-1:0]    valid_r;

  // Per-reference working registers.
  logic [PAGE_BITS-1:0] pg_r;
  logic                 hit_r;
  logic [IDX_W-1:0]     hit_idx_r;
  logic                 free_r;
  logic [IDX_W-1:0]     free_idx_r;
  logic [AGE_W-1:0]     min_age_r;
  logic [IDX_W-1:0]     min_idx_r;
  logic [PAGE_BITS-1:0] min_page_r;
  logic [IDX_W-1:0]     slot_r;
  logic                 miss_r;
  logic                 ev_r;
  logic [PAGE_BITS-1:0] ev_page_r;

  // Output register.
  logic                          out_valid_r;
  logic                          out_hit_r;
  logic [apr_pkg::IDX_OUT_W-1:0] out_idx_r;
  logic                          out_ev_r;
  logic [PAGE_BITS-1:0]          out_ev_page_r;

  // Control decoded from the state.
  logic in_ready;
  logic accept;
  logic scan_st;
  logic age_st;
  logic fill_st;
  logic done_st;
  logic load_out;
  logic issue;
  logic pass_end;

  // Memory ports and compare unit.
  logic [IDX_W-1:0]     rd_addr;
  logic [PAGE_BITS-1:0] page_rd;
  logic [AGE_W-1:0]     age_rd;
  logic                 page_we;
  logic [IDX_W-1:0]     fill_slot;
  logic                 age_we;
  logic [AGE_W-1:0]     age_wdata;
  logic [AGE_W-1:0]     age_shr;
  logic                 chk_valid;
  logic [AGE_W-1:0]     chk_age;
  logic                 page_eq;
  logic                 take_min;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign reg_idx = paddr[apr_pkg::APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_idx)
      apr_pkg::REG_FRAMES_IN_USE: prdata = apr_pkg::APB_DATA_W'(frames_in_use_r);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= apr_pkg::CFG_RESET;
    end else if (cfg_wr && (reg_idx == apr_pkg::REG_FRAMES_IN_USE)) begin
      frames_in_use_r <= pwdata[apr_pkg::CFG_W-1:0];
    end
  end

  // A limit of zero behaves as one frame, and any limit above the table as the table.
  assign lim_ext = LIM_W'(frames_in_use_r);
  assign n_act   = (lim_ext == '0)              ? CNT_W'(1) :
                   (lim_ext > LIM_W'(FRAMES))   ? CNT_W'(FRAMES) :
                                                  CNT_W'(lim_ext);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign issue    = (scan_st || age_st) && (cnt_r < n_r);
  assign pass_end = (cnt_r == n_r) && !chk_v_r;
  assign rd_addr  = cnt_r[IDX_W-1:0];
  assign accept   = in_ch.valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      apr_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = apr_pkg::ST_SCAN;
        end
      end
      apr_pkg::ST_SCAN: begin
        if (pass_end) begin
          state_nxt = apr_pkg::ST_FILL;
        end
      end
      apr_pkg::ST_FILL: begin
        state_nxt = apr_pkg::ST_AGE;
      end
      apr_pkg::ST_AGE: begin
        if (pass_end) begin
          state_nxt = apr_pkg::ST_DONE;
        end
      end
      apr_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = apr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = apr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    scan_st  = 1'b0;
    fill_st  = 1'b0;
    age_st   = 1'b0;
    done_st  = 1'b0;
    unique case (state_r)
      apr_pkg::ST_IDLE: in_ready = 1'b1;
      apr_pkg::ST_SCAN: scan_st  = 1'b1;
      apr_pkg::ST_FILL: fill_st  = 1'b1;
      apr_pkg::ST_AGE:  age_st   = 1'b1;
      apr_pkg::ST_DONE: done_st  = 1'b1;
      default: ;
    endcase
  end

  assign load_out = done_st && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apr_pkg::ST_IDLE;
      chk_v_r     <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chk_v_r <= issue;
      if (fill_st) begin
        valid_r[fill_slot] <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Compare unit: one frame per cycle during the scan pass
  // --------------------------------------------------------------------------
  assign chk_valid = valid_r[chk_idx_r];
  assign chk_age   = chk_valid ? age_rd : '0;
  assign page_eq   = chk_valid && (page_rd == pg_r);
  assign take_min  = (chk_idx_r == '0) || (chk_age < min_age_r);

  assign fill_slot = hit_r  ? hit_idx_r :
                     free_r ? free_idx_r : min_idx_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      pg_r   <= in_ch.page_number;
      n_r    <= n_act;
      cnt_r  <= '0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end
    if (issue) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
    chk_idx_r <= rd_addr;
    if (scan_st && chk_v_r) begin
      if (!hit_r && page_eq) begin
        hit_r     <= 1'b1;
        hit_idx_r <= chk_idx_r;
      end
      if (!free_r && !chk_valid) begin
        free_r     <= 1'b1;
        free_idx_r <= chk_idx_r;
      end
      if (take_min) begin
        min_age_r  <= chk_age;
        min_idx_r  <= chk_idx_r;
        min_page_r <= page_rd;
      end
    end
    if (fill_st) begin
      cnt_r     <= '0;
      slot_r    <= fill_slot;
      miss_r    <= !hit_r;
      ev_r      <= !hit_r && !free_r;
      ev_page_r <= (!hit_r && !free_r) ? min_page_r : '0;
    end
    if (load_out) begin
      out_hit_r     <= !miss_r;
      out_idx_r     <= apr_pkg::IDX_OUT_W'(slot_r);
      out_ev_r      <= ev_r;
      out_ev_page_r <= ev_page_r;
    end
  end

  // --------------------------------------------------------------------------
  // Aging pass: read one age, write it back shifted on the next cycle
  // --------------------------------------------------------------------------
  // A freshly filled frame starts at zero, so after the shift it holds only
  // the top bit.
  assign age_shr   = {1'b0, age_rd[AGE_W-1:1]};
  assign age_wdata = (chk_idx_r != slot_r) ? age_shr :
                     miss_r                ? apr_pkg::AGE_TOP :
                                             (age_shr | apr_pkg::AGE_TOP);
  assign age_we    = age_st && chk_v_r && chk_valid;
  assign page_we   = fill_st && !hit_r;

  apr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (fill_slot),
    .wdata (pg_r),
    .raddr (rd_addr),
    .rdata (page_rd)
  );

  apr_ram #(
    .WIDTH (AGE_W),
    .DEPTH (FRAMES)
  ) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (chk_idx_r),
    .wdata (age_wdata),
    .raddr (rd_addr),
    .rdata (age_rd)
  );

  // --------------------------------------------------------------------------
  // Channels
  // --------------------------------------------------------------------------
  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.frame_index   = out_idx_r;
  assign out_ch.evicted_valid = out_ev_r;
  assign out_ch.evicted_page  = out_ev_page_r;

endmodule

@@ hw/rtl/apr_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module apr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Aging page replacement testbench
// Streams page references through the block under bursty input and
// stalling output. A model of the frame table inside the checker class
// predicts the hit, the frame and the eviction for each accepted reference,
// and every result beat is compared with the oldest prediction. The frame
// limit register is rewritten between phases, including its extremes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FRAMES     = apr_pkg::FRAMES_DEF;
  localparam int PAGE_BITS  = apr_pkg::PAGE_BITS_DEF;
  localparam int SETTLE     = 2 * FRAMES + 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 400;
  localparam int HOLD_AFTER = 600;
  localparam int MAX_REPORTS = 10;

  // Index with no register behind it; writes there must be ignored.
  localparam logic [apr_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 1'd1;

  typedef logic [PAGE_BITS-1:0] page_t;

  typedef struct packed {
    logic                          hit;
    logic [apr_pkg::IDX_OUT_W-1:0] frame_index;
    logic                          evicted_valid;
    page_t                         evicted_page;
  } lookup_result_t;

  class aging_table_checker;
    page_t          frame_page  [FRAMES];
    logic [apr_pkg::AGE_W-1:0] frame_age [FRAMES];
    bit             frame_valid [FRAMES];
    logic [apr_pkg::CFG_W-1:0] frame_limit;
    lookup_result_t expected_results[$];
    int             errors;
    int             results_seen;

    function new();
      for (int i = 0; i < FRAMES; i++) begin
        frame_page[i]  = '0;
        frame_age[i]   = '0;
        frame_valid[i] = 1'b0;
      end
      frame_limit  = apr_pkg::CFG_RESET;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_register(logic [apr_pkg::REG_IDX_W-1:0] idx,
                                 logic [apr_pkg::APB_DATA_W-1:0] value);
      if (idx == apr_pkg::REG_FRAMES_IN_USE) begin
        frame_limit = value[apr_pkg::CFG_W-1:0];
      end
    endfunction

    function int active_frames();
      if (frame_limit == 0) return 1;
      if (frame_limit > FRAMES) return FRAMES;
      return int'(frame_limit);
    endfunction

    // Lookup, fill or evict, then age every valid active frame.
    function void predict_reference(page_t page);
      int n;
      int slot;
      bit found;
      lookup_result_t r;
      n     = active_frames();
      slot  = 0;
      found = 1'b0;
      r     = '0;
      for (int i = 0; i < n; i++) begin
        if (!found && frame_valid[i] && frame_page[i] == page) begin
          slot  = i;
          found = 1'b1;
          r.hit = 1'b1;
        end
      end
      for (int i = 0; i < n; i++) begin
        if (!found && !frame_valid[i]) begin
          slot  = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        slot = 0;
        for (int i = 1; i < n; i++) begin
          if (frame_age[i] < frame_age[slot]) slot = i;
        end
        r.evicted_valid = 1'b1;
        r.evicted_page  = frame_page[slot];
      end
      if (!r.hit) begin
        frame_page[slot]  = page;
        frame_age[slot]   = '0;
        frame_valid[slot] = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        if (frame_valid[i]) begin
          frame_age[i] = (frame_age[i] >> 1) | ((i == slot) ? apr_pkg::AGE_TOP : '0);
        end
      end
      r.frame_index = slot[apr_pkg::IDX_OUT_W-1:0];
      expected_results.push_back(r);
    endfunction

    function void report(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR: %s", what);
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        report($sformatf("result beat with nothing expected: hit=%0d frame=%0d ev=%0d page=%05h",
                         got.hit, got.frame_index, got.evicted_valid, got.evicted_page));
        return;
      end
      want = expected_results.pop_front();
      if (got.hit != want.hit || got.frame_index != want.frame_index ||
          got.evicted_valid != want.evicted_valid || got.evicted_page != want.evicted_page) begin
        report($sformatf({"result %0d: expected hit=%0d frame=%0d ev=%0d page=%05h, ",
                          "got hit=%0d frame=%0d ev=%0d page=%05h"},
                         results_seen, want.hit, want.frame_index, want.evicted_valid,
                         want.evicted_page, got.hit, got.frame_index, got.evicted_valid,
                         got.evicted_page));
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [apr_pkg::APB_ADDR_W-1:0] paddr;
  logic [apr_pkg::APB_DATA_W-1:0] pwdata;
  logic [apr_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  apr_in_if  #(.PAGE_BITS(PAGE_BITS)) in_ch ();
  apr_out_if #(.PAGE_BITS(PAGE_BITS)) out_ch ();

  aging_page_replacement #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  aging_table_checker table_check = new();

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Both channels are sampled here with the values the block saw at the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) table_check.predict_reference(in_ch.page_number);
      if (out_ch.valid && out_ch.ready) begin
        table_check.check_result({out_ch.hit, out_ch.frame_index, out_ch.evicted_valid,
                                  out_ch.evicted_page});
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("aging_page_replacement verification failed");
    $finish;
  end

  // Result side: stretches of steady, random and sparse ready, plus one long
  // hold-off so the block fills up and has to stall new references.
  initial begin : result_sink
    int mode;
    int len;
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held && table_check.results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        for (int c = 0; c < HOLD_LEN; c++) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(4, 80);
      for (int c = 0; c < len; c++) begin
        case (mode)
          0: begin
            out_ch.ready <= 1'b1;
          end
          1: begin
            out_ch.ready <= $urandom_range(0, 1);
          end
          2: begin
            out_ch.ready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_ch.ready <= (c % 5 == 0);
          end
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_page(input page_t page);
    in_ch.valid       <= 1'b1;
    in_ch.page_number <= page;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Lets every outstanding result arrive and the block fall idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (table_check.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic [apr_pkg::REG_IDX_W-1:0] idx,
                                input logic [apr_pkg::APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    table_check.write_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic page_t random_page();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return r[PAGE_BITS-1:0];
    endcase
  endfunction

  initial begin : stimulus
    logic [apr_pkg::APB_DATA_W-1:0] limits[10];
    page_t pool[$];
    int act;
    int burst_left;
    int gap;

    // Raw register values; the upper bits and out-of-range limits are deliberate.
    limits = '{32'd16, 32'd1, 32'd15, 32'd0, 32'd31, 32'd2, 32'hFFFF_FFE7, 32'd16, 32'd3,
               32'h2A};

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.page_number = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Two frames: cold fills, a hit, evictions by age.
    write_register(apr_pkg::REG_FRAMES_IN_USE, 32'd2);
    send_page('0);
    send_page('1);
    send_page('0);
    send_page(20'h55555);
    send_page(20'hAAAAA);
    send_page('1);
    send_page('0);
    drain();

    // A limit of zero behaves as one frame.
    write_register(apr_pkg::REG_FRAMES_IN_USE, 32'd0);
    send_page(20'h00001);
    send_page(20'h00001);
    send_page(20'h80000);
    drain();

    // Raising the limit brings back frames that kept their old pages.
    write_register(apr_pkg::REG_FRAMES_IN_USE, 32'h23);
    send_page(20'h55555);
    send_page(20'hAAAAA);
    send_page('1);
    send_page(20'h7FFFF);
    drain();

    // A write to an unmapped register changes nothing.
    write_register(REG_UNMAPPED, 32'd1);
    send_page(20'h12345);
    send_page('0);
    drain();

    // A limit above the table size behaves as the full table.
    write_register(apr_pkg::REG_FRAMES_IN_USE, 32'd31);
    send_page('1);
    send_page(20'h0F0F0);
    drain();

    // Random phases: references mostly come from a working set sized near
    // the frame count, so hits and evictions both happen often.
    burst_left = 0;
    foreach (limits[p]) begin
      write_register(apr_pkg::REG_FRAMES_IN_USE, limits[p]);
      act = table_check.active_frames();
      pool.delete();
      repeat ($urandom_range(1, act + 6)) pool.push_back(random_page());
      for (int k = 0; k < 190; k++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 24);
        end
        if ($urandom_range(0, 19) == 0) pool[$urandom_range(0, pool.size() - 1)] = random_page();
        if ($urandom_range(0, 9) < 7) send_page(pool[$urandom_range(0, pool.size() - 1)]);
        else send_page(random_page());
        burst_left--;
      end
      drain();
    end

    if (table_check.pending() != 0) table_check.report("results still outstanding at the end");
    if (table_check.errors == 0) begin
      $display("aging_page_replacement verification clean");
    end else begin
      $display("aging_page_replacement verification failed");
    end
    $finish;
  end
endmodule
